// ===== hw/rtl/s5hp_pkg.sv =====
// Shared constants and types for the SOCKS5 handshake parser.
package s5hp_pkg;

  localparam int HOST_BYTES_DEF = 256;
  localparam int IN_DATA_W      = 8;
  localparam int OUT_DATA_W     = 40;
  localparam int KIND_W         = 2;

  localparam logic [7:0] SOCKS_VER    = 8'h05;
  localparam logic [7:0] CMD_CONNECT  = 8'h01;
  localparam logic [7:0] METH_NOAUTH  = 8'h00;
  localparam logic [7:0] RSV_ZERO     = 8'h00;
  localparam logic [7:0] ATYP_IPV4    = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN  = 8'h03;
  localparam logic [7:0] ATYP_IPV6    = 8'h04;
  localparam logic [7:0] IPV4_LEN     = 8'd4;
  localparam logic [7:0] IPV6_LEN     = 8'd16;

  typedef enum logic [1:0] {
    REPLY_NONE      = 2'd0,
    REPLY_ACCEPT    = 2'd1,
    REPLY_AUTH_FAIL = 2'd2,
    REPLY_PROTO_ERR = 2'd3
  } reply_t;

  typedef enum logic [1:0] {
    KIND_IPV4   = 2'd0,
    KIND_DOMAIN = 2'd1,
    KIND_IPV6   = 2'd2
  } kind_t;

  typedef struct packed {
    logic        ignored;
    logic [15:0] port;
    logic        ready_res;
    logic [7:0]  host_byte;
    logic [7:0]  host_index;
    logic        host_valid;
    logic        closed;
    reply_t      reply;
  } result_t;

endpackage

// ===== hw/rtl/socks5_handshake_parser.sv =====
// SOCKS5 client handshake parser top level.
// Usage:
//   Input stream: one item per accepted beat. in_tuser = 1 opens a fresh
//   negotiation (in_tdata ignored); in_tuser = 0 carries one client byte.
//   Result stream: exactly one result per accepted input item, in order.
//   Each result gives the reply code, close flag, echoed address byte with
//   its index, ready flag with the destination port, and an ignored flag.
//   out_tuser carries the address kind.
// The result is registered and becomes valid in the cycle after input accept.
// Throughput: one item per cycle while out_tready is high; parse state updates
//   on every accepted item and the result lands in one output register.
// Stall: in_tready follows out_tready while a result is held, so a stalled
//   receiver holds the input side only while the output register is full.
// Address bytes are written into a HOST_BYTES-deep RAM as they arrive.
// Reset: synchronous active-low rst_n returns the parser to idle with no
//   negotiation open and the output register empty; the host RAM is not
//   cleared.
module socks5_handshake_parser #(
  parameter int HOST_BYTES = s5hp_pkg::HOST_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [s5hp_pkg::IN_DATA_W-1:0]  in_tdata,   // [7:0] data
  input  logic                            in_tuser,   // [0] mode
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [1:0] reply, [2] closed, [3] host_valid, [11:4] host_index,
  // [19:12] host_byte, [20] ready_res, [36:21] port, [37] ignored, [39:38] zero
  output logic [s5hp_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [s5hp_pkg::KIND_W-1:0]     out_tuser   // [1:0] addr_kind
);
  import s5hp_pkg::*;

  localparam int AW = $clog2(HOST_BYTES);
  localparam logic [8:0] HOST_LIMIT = 9'(HOST_BYTES);

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_GREET   = 4'd1,
    PH_NMETH   = 4'd2,
    PH_METHODS = 4'd3,
    PH_REQVER  = 4'd4,
    PH_CMD     = 4'd5,
    PH_RSV     = 4'd6,
    PH_ATYP    = 4'd7,
    PH_DLEN    = 4'd8,
    PH_ADDR    = 4'd9,
    PH_PORTHI  = 4'd10,
    PH_PORTLO  = 4'd11,
    PH_READY   = 4'd12
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  methods_left_r, methods_left_nxt;
  logic        noauth_seen_r, noauth_seen_nxt;
  kind_t       kind_r, kind_nxt;
  logic [7:0]  host_length_r, host_length_nxt;
  logic [7:0]  host_count_r, host_count_nxt;
  logic [7:0]  port_high_r, port_high_nxt;

  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  kind_t                 out_kind_r;

  result_t    res;
  logic       in_fire;
  logic [7:0] d;
  logic [7:0] methods_dec;
  logic [7:0] count_inc;
  logic       ram_wr;

  assign in_tready = !out_tvalid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign d         = in_tdata[7:0];
  assign methods_dec = methods_left_r - 8'd1;
  assign count_inc   = host_count_r + 8'd1;

  always_comb begin
    phase_nxt        = phase_r;
    methods_left_nxt = methods_left_r;
    noauth_seen_nxt  = noauth_seen_r;
    kind_nxt         = kind_r;
    host_length_nxt  = host_length_r;
    host_count_nxt   = host_count_r;
    port_high_nxt    = port_high_r;
    res              = '0;
    ram_wr           = 1'b0;

    if (in_tuser) begin
      phase_nxt        = PH_GREET;
      methods_left_nxt = '0;
      noauth_seen_nxt  = 1'b0;
      kind_nxt         = KIND_IPV4;
      host_length_nxt  = '0;
      host_count_nxt   = '0;
      port_high_nxt    = '0;
    end else begin
      unique case (phase_r)
        PH_IDLE, PH_READY: begin
          res.ignored = 1'b1;
        end
        PH_GREET: begin
          if (d == SOCKS_VER) begin
            phase_nxt = PH_NMETH;
          end else begin
            res.closed = 1'b1;
            phase_nxt  = PH_IDLE;
          end
        end
        PH_NMETH: begin
          if (d == 8'd0) begin
            res.reply  = REPLY_AUTH_FAIL;
            res.closed = 1'b1;
            phase_nxt  = PH_IDLE;
          end else begin
            methods_left_nxt = d;
            noauth_seen_nxt  = 1'b0;
            phase_nxt        = PH_METHODS;
          end
        end
        PH_METHODS: begin
          noauth_seen_nxt  = noauth_seen_r || (d == METH_NOAUTH);
          methods_left_nxt = methods_dec;
          if (methods_dec == 8'd0) begin
            if (noauth_seen_nxt) begin
              res.reply = REPLY_ACCEPT;
              phase_nxt = PH_REQVER;
            end else begin
              res.reply  = REPLY_AUTH_FAIL;
              res.closed = 1'b1;
              phase_nxt  = PH_IDLE;
            end
          end
        end
        PH_REQVER, PH_CMD, PH_RSV: begin
          if ((phase_r == PH_REQVER && d == SOCKS_VER) ||
              (phase_r == PH_CMD && d == CMD_CONNECT) ||
              (phase_r == PH_RSV && d == RSV_ZERO)) begin
            phase_nxt = phase_t'(phase_r + 4'd1);
          end else begin
            res.reply  = REPLY_PROTO_ERR;
            res.closed = 1'b1;
            phase_nxt  = PH_IDLE;
          end
        end
        PH_ATYP: begin
          host_count_nxt  = '0;
          host_length_nxt = '0;
          if (d == ATYP_IPV4) begin
            kind_nxt        = KIND_IPV4;
            host_length_nxt = IPV4_LEN;
            phase_nxt       = PH_ADDR;
          end else if (d == ATYP_DOMAIN) begin
            kind_nxt  = KIND_DOMAIN;
            phase_nxt = PH_DLEN;
          end else if (d == ATYP_IPV6) begin
            kind_nxt        = KIND_IPV6;
            host_length_nxt = IPV6_LEN;
            phase_nxt       = PH_ADDR;
          end else begin
            res.reply  = REPLY_PROTO_ERR;
            res.closed = 1'b1;
            phase_nxt  = PH_IDLE;
          end
        end
        PH_DLEN: begin
          if (d == 8'd0 || {1'b0, d} > HOST_LIMIT) begin
            res.reply  = REPLY_PROTO_ERR;
            res.closed = 1'b1;
            phase_nxt  = PH_IDLE;
          end else begin
            host_length_nxt = d;
            phase_nxt       = PH_ADDR;
          end
        end
        PH_ADDR: begin
          if ({1'b0, host_count_r} < HOST_LIMIT) begin
            ram_wr         = 1'b1;
            res.host_valid = 1'b1;
            res.host_index = host_count_r;
            res.host_byte  = d;
          end
          host_count_nxt = count_inc;
          if ({1'b0, count_inc} >= {1'b0, host_length_r} || count_inc == 8'd0) begin
            phase_nxt = PH_PORTHI;
          end
        end
        PH_PORTHI: begin
          port_high_nxt = d;
          phase_nxt     = PH_PORTLO;
        end
        PH_PORTLO: begin
          res.ready_res = 1'b1;
          res.port      = {port_high_r, d};
          phase_nxt     = PH_READY;
        end
        default: begin
          res.closed = 1'b1;
          phase_nxt  = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      methods_left_r <= '0;
      noauth_seen_r  <= 1'b0;
      kind_r         <= KIND_IPV4;
      host_length_r  <= '0;
      host_count_r   <= '0;
      port_high_r    <= '0;
      out_tvalid_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r        <= phase_nxt;
        methods_left_r <= methods_left_nxt;
        noauth_seen_r  <= noauth_seen_nxt;
        kind_r         <= kind_nxt;
        host_length_r  <= host_length_nxt;
        host_count_r   <= host_count_nxt;
        port_high_r    <= port_high_nxt;
        out_tvalid_r   <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_tdata_r <= OUT_DATA_W'(res);
      out_kind_r  <= kind_nxt;
    end
  end

  s5hp_ram #(
    .WIDTH (8),
    .DEPTH (HOST_BYTES)
  ) u_host_ram (
    .clk     (clk),
    .wr_en   (in_fire && !in_tuser && ram_wr),
    .wr_addr (host_count_r[AW-1:0]),
    .wr_data (d),
    .rd_en   (1'b0),
    .rd_addr ('0),
    .rd_data ()
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_kind_r;

  a_close_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && res.closed |=> phase_r == PH_IDLE)
    else $error("close did not return parser to idle");

  a_ready_phase: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && res.ready_res |=> phase_r == PH_READY && out_tvalid_r)
    else $error("completed request not held in ready phase");

  a_open_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tuser |=> phase_r == PH_GREET && host_count_r == 8'd0)
    else $error("new negotiation did not clear parser state");

  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && res.reply == REPLY_ACCEPT |=> phase_r == PH_REQVER)
    else $error("accept reply without moving to request phase");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && !out_tready |=> out_tvalid_r && $stable(out_tdata_r))
    else $error("stalled result changed");

endmodule

// ===== hw/rtl/s5hp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module s5hp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
